>>> rtl/core/ppbu_pkg.sv
// ----------------------------------------------------------------------------
// ppbu_pkg
// Shared types and constants for the polygon perimeter and bounds unit:
// coordinate and accumulator widths, beat payload structs, FSM state types.
// ----------------------------------------------------------------------------
`default_nettype none

package ppbu_pkg;

	// Fixed field widths of the beat payloads
	localparam int COORD_BITS = 16;
	localparam int ACC_BITS   = 40;

	// Input beat: one vertex
	typedef struct packed {
		logic signed [COORD_BITS-1:0] vertex_x;
		logic signed [COORD_BITS-1:0] vertex_y;
		logic                         last_vertex;
	} ppbu_in_t;

	// Output beat: perimeter and bounding box of one polygon
	typedef struct packed {
		logic [ACC_BITS-1:0]          perimeter;
		logic                         perimeter_saturated;
		logic signed [COORD_BITS-1:0] box_x_min;
		logic signed [COORD_BITS-1:0] box_y_min;
		logic signed [COORD_BITS-1:0] box_x_max;
		logic signed [COORD_BITS-1:0] box_y_max;
	} ppbu_out_t;

	// Top-level sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EDGE,
		ST_CLOSE,
		ST_FIN
	} ppbu_state_t;

	// Edge length unit sequencer
	typedef enum logic [1:0] {
		EL_IDLE,
		EL_SQX,
		EL_SQY,
		EL_ROOT
	} ppbu_el_state_t;

endpackage

`default_nettype wire

>>> rtl/core/polygon_perimeter_and_bounds_unit.sv
// ----------------------------------------------------------------------------
// polygon_perimeter_and_bounds_unit
// Vertex stream in, perimeter and bounding box of each polygon out.
// ----------------------------------------------------------------------------
// Vertices arrive one per input beat; the beat flagged last_vertex closes the
// polygon and produces one output beat with the saturating perimeter (8
// fraction bits by default) and the bounding box, after which the unit starts
// fresh. close_ring (reset 1) adds the edge from the last vertex back to the
// first. The unit holds one vertex at a time: the first vertex of a polygon
// only seeds the polygon state, every other vertex runs the edge unit, one
// shared squarer plus a one-bit-per-cycle square root of COORD_BITS + 1 +
// FRAC_BITS steps; a last vertex with close_ring set runs the edge unit
// twice, and any last vertex then passes a finish state that posts the
// result. The result sits in an output register, so the next polygon can
// start while it waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_perimeter_and_bounds_unit
	import ppbu_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire ppbu_in_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output ppbu_out_t      out_data,
	input  wire logic      cfg_we,
	input  wire logic      cfg_wdata
);

	localparam int ROOT_W = COORD_BITS + 1 + FRAC_BITS;
	localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

	ppbu_state_t state_q, state_d;

	logic                         close_ring_q;
	logic                         have_first_q;
	logic                         out_valid_q;
	ppbu_out_t                    out_q;

	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q;
	logic                         cur_last_q;
	logic signed [COORD_BITS-1:0] first_x_q, first_y_q;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic signed [COORD_BITS-1:0] min_x_q, min_y_q, max_x_q, max_y_q;
	logic [ACC_BITS-1:0]          acc_q;
	logic                         sat_q;

	logic                         edge_start, edge_close, edge_done;
	logic [ROOT_W-1:0]            edge_len;
	logic signed [COORD_BITS-1:0] op_ax, op_ay, op_bx, op_by;
	logic                         acc_add, out_load, out_free, init_first, box_upd;
	logic [ACC_BITS:0]            acc_sum;
	logic [ACC_BITS-1:0]          acc_new;

	// Edge operands: previous-to-current, or current back to first
	always_comb begin
		op_ax = edge_close ? cur_x_q   : prev_x_q;
		op_ay = edge_close ? cur_y_q   : prev_y_q;
		op_bx = edge_close ? first_x_q : cur_x_q;
		op_by = edge_close ? first_y_q : cur_y_q;
	end

	ppbu_edge_len #(
		.FRAC_BITS (FRAC_BITS)
	) u_edge_len (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (edge_start),
		.ax     (op_ax),
		.ay     (op_ay),
		.bx     (op_bx),
		.by     (op_by),
		.done   (edge_done),
		.len    (edge_len)
	);

	// Saturating accumulate
	always_comb begin
		acc_sum = {1'b0, acc_q} + {{(ACC_BITS + 1 - ROOT_W){1'b0}}, edge_len};
		acc_new = acc_sum[ACC_BITS] ? ACC_MAX : acc_sum[ACC_BITS-1:0];
	end

	assign out_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (have_first_q) state_d = ST_EDGE;
				else if (cur_last_q) state_d = ST_FIN;
				else state_d = ST_IDLE;
			end
			ST_EDGE: begin
				if (edge_done) begin
					if (cur_last_q && close_ring_q) state_d = ST_CLOSE;
					else if (cur_last_q) state_d = ST_FIN;
					else state_d = ST_IDLE;
				end
			end
			ST_CLOSE: begin
				if (edge_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		init_first = (state_q == ST_LOAD) && !have_first_q;
		box_upd    = (state_q == ST_LOAD) && have_first_q;
		edge_close = (state_q == ST_EDGE);
		edge_start = box_upd
		          || ((state_q == ST_EDGE) && edge_done && cur_last_q && close_ring_q);
		acc_add    = ((state_q == ST_EDGE) || (state_q == ST_CLOSE)) && edge_done;
		out_load   = (state_q == ST_FIN) && out_free;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			close_ring_q <= 1'b1;
			have_first_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) close_ring_q <= cfg_wdata;
			if (init_first) have_first_q <= 1'b1;
			else if (out_load) have_first_q <= 1'b0;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Vertex, box and sum registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cur_x_q    <= in_data.vertex_x;
			cur_y_q    <= in_data.vertex_y;
			cur_last_q <= in_data.last_vertex;
		end
		if (init_first) begin
			first_x_q <= cur_x_q;
			first_y_q <= cur_y_q;
			prev_x_q  <= cur_x_q;
			prev_y_q  <= cur_y_q;
			min_x_q   <= cur_x_q;
			min_y_q   <= cur_y_q;
			max_x_q   <= cur_x_q;
			max_y_q   <= cur_y_q;
			acc_q     <= '0;
			sat_q     <= 1'b0;
		end
		if (box_upd) begin
			if (cur_x_q < min_x_q) min_x_q <= cur_x_q;
			if (cur_y_q < min_y_q) min_y_q <= cur_y_q;
			if (cur_x_q > max_x_q) max_x_q <= cur_x_q;
			if (cur_y_q > max_y_q) max_y_q <= cur_y_q;
		end
		if (acc_add) begin
			acc_q <= acc_new;
			if (acc_new == ACC_MAX) sat_q <= 1'b1;
		end
		// previous vertex advances once its edge is in
		if ((state_q == ST_EDGE) && edge_done) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
		end
		if (out_load) begin
			out_q.perimeter           <= acc_q;
			out_q.perimeter_saturated <= sat_q;
			out_q.box_x_min           <= min_x_q;
			out_q.box_y_min           <= min_y_q;
			out_q.box_x_max           <= max_x_q;
			out_q.box_y_max           <= max_y_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

>>> rtl/core/ppbu_edge_len.sv
// ----------------------------------------------------------------------------
// ppbu_edge_len
// Euclidean edge length between two points in fixed point: one shared
// multiplier squares dx then dy, then a digit-by-digit square root takes one
// root bit per cycle. Result is floor(sqrt((dx^2 + dy^2) << 2*FRAC_BITS)).
// ----------------------------------------------------------------------------
`default_nettype none

module ppbu_edge_len
	import ppbu_pkg::*;
#(
	parameter int FRAC_BITS = 8,
	localparam int ROOT_W = COORD_BITS + 1 + FRAC_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic signed [COORD_BITS-1:0] ax,
	input  wire logic signed [COORD_BITS-1:0] ay,
	input  wire logic signed [COORD_BITS-1:0] bx,
	input  wire logic signed [COORD_BITS-1:0] by,
	output logic                              done,
	output logic [ROOT_W-1:0]                 len
);

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 2;
	localparam int CNT_W  = $clog2(ROOT_W);

	ppbu_el_state_t state_q, state_d;

	logic [DIFF_W-1:0] dx_q, dy_q;
	logic [SQ_W-1:0]   sq_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;

	logic signed [DIFF_W-1:0] diff_x, diff_y;
	logic [DIFF_W-1:0]        abs_x, abs_y;
	logic [DIFF_W-1:0]        mul_in;
	logic [SQ_W-1:0]          prod;
	logic [REM_W-1:0]         rem_sh, trial;
	logic                     take;
	logic                     ld_start, do_sqx, do_sqy, do_step, last_step;

	// Absolute coordinate differences
	always_comb begin
		diff_x = {ax[COORD_BITS-1], ax} - {bx[COORD_BITS-1], bx};
		diff_y = {ay[COORD_BITS-1], ay} - {by[COORD_BITS-1], by};
		abs_x  = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
		abs_y  = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
	end

	// Shared squarer
	assign mul_in = (state_q == EL_SQX) ? dx_q : dy_q;
	assign prod   = mul_in * mul_in;

	// One root digit: bring down two radicand bits, trial subtract
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		take   = (rem_sh >= trial);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			EL_IDLE: if (start) state_d = EL_SQX;
			EL_SQX:  state_d = EL_SQY;
			EL_SQY:  state_d = EL_ROOT;
			EL_ROOT: if (cnt_q == '0) state_d = EL_IDLE;
			default: state_d = EL_IDLE;
		endcase
	end

	// Datapath controls
	always_comb begin
		ld_start  = (state_q == EL_IDLE) && start;
		do_sqx    = (state_q == EL_SQX);
		do_sqy    = (state_q == EL_SQY);
		do_step   = (state_q == EL_ROOT);
		last_step = do_step && (cnt_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EL_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= last_step;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (ld_start) begin
			dx_q <= abs_x;
			dy_q <= abs_y;
		end
		if (do_sqx) begin
			sq_q <= prod;
		end
		if (do_sqy) begin
			rad_q  <= RAD_W'(sq_q + prod) << (2 * FRAC_BITS);
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= CNT_W'(ROOT_W - 1);
		end
		if (do_step) begin
			rad_q  <= rad_q << 2;
			rem_q  <= take ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], take};
			cnt_q  <= cnt_q - 1'b1;
		end
	end

	assign done = done_q;
	assign len  = root_q;

endmodule

`default_nettype wire

>>> tb/perimeter_bounds_checker.sv
// ----------------------------------------------------------------------------
// perimeter_bounds_checker
// Watches the vertex and result channels of the perimeter and bounds unit.
// It keeps its own copy of the polygon state and the close_ring register,
// works out the perimeter and bounding box for every polygon that closes,
// and compares each result beat field by field against the oldest one.
// ----------------------------------------------------------------------------

module perimeter_bounds_checker
	import ppbu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  ppbu_in_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  ppbu_out_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	output int        mismatches,
	output int        pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int                  FRAC_BITS    = 8;
	localparam logic [ACC_BITS-1:0] ACC_MAX      = '1;
	localparam int                  REPORT_LIMIT = 10;

	// Polygon state as the unit should hold it
	logic signed [COORD_BITS-1:0] anchor_x, anchor_y, trail_x, trail_y;
	logic signed [COORD_BITS-1:0] lo_x, lo_y, hi_x, hi_y;
	logic [ACC_BITS-1:0]          perim_sum;
	logic                         perim_sat;
	logic                         in_polygon;
	logic                         close_ring;

	ppbu_out_t polygon_results_q[$];
	int        beats_out;

	// Floored root of (dx^2 + dy^2) scaled by 2^(2*FRAC_BITS), two bits per step
	function automatic logic [ACC_BITS-1:0] edge_length(
		input logic signed [COORD_BITS-1:0] ax, ay, bx, by);
		longint          dx, dy;
		longint unsigned radicand, rem, root, trial;
		int              i;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		radicand = dx * dx + dy * dy;
		radicand = radicand << (2 * FRAC_BITS);
		rem  = 0;
		root = 0;
		for (i = 31; i >= 0; i--) begin
			rem   = (rem << 2) | ((radicand >> (2 * i)) & 64'd3);
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem  = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root[ACC_BITS-1:0];
	endfunction

	// Saturating add; the flag sticks once the sum sits at its ceiling
	function automatic void accumulate_edge(input logic [ACC_BITS-1:0] len);
		if (len > ACC_MAX - perim_sum)
			perim_sum = ACC_MAX;
		else
			perim_sum = perim_sum + len;
		if (perim_sum == ACC_MAX)
			perim_sat = 1'b1;
	endfunction

	function automatic void clear_polygon();
		anchor_x   = '0;
		anchor_y   = '0;
		trail_x    = '0;
		trail_y    = '0;
		lo_x       = '0;
		lo_y       = '0;
		hi_x       = '0;
		hi_y       = '0;
		perim_sum  = '0;
		perim_sat  = 1'b0;
		in_polygon = 1'b0;
	endfunction

	function automatic void predict_vertex(input ppbu_in_t v);
		ppbu_out_t summary;
		if (!in_polygon) begin
			// opening vertex seeds the box and restarts the sum
			anchor_x   = v.vertex_x;
			anchor_y   = v.vertex_y;
			trail_x    = v.vertex_x;
			trail_y    = v.vertex_y;
			lo_x       = v.vertex_x;
			hi_x       = v.vertex_x;
			lo_y       = v.vertex_y;
			hi_y       = v.vertex_y;
			perim_sum  = '0;
			perim_sat  = 1'b0;
			in_polygon = 1'b1;
		end else begin
			accumulate_edge(edge_length(trail_x, trail_y, v.vertex_x, v.vertex_y));
			trail_x = v.vertex_x;
			trail_y = v.vertex_y;
			if (v.vertex_x < lo_x) lo_x = v.vertex_x;
			if (v.vertex_y < lo_y) lo_y = v.vertex_y;
			if (v.vertex_x > hi_x) hi_x = v.vertex_x;
			if (v.vertex_y > hi_y) hi_y = v.vertex_y;
		end
		if (v.last_vertex) begin
			if (close_ring)
				accumulate_edge(edge_length(v.vertex_x, v.vertex_y, anchor_x, anchor_y));
			summary.perimeter           = perim_sum;
			summary.perimeter_saturated = perim_sat;
			summary.box_x_min           = lo_x;
			summary.box_y_min           = lo_y;
			summary.box_x_max           = hi_x;
			summary.box_y_max           = hi_y;
			polygon_results_q.push_back(summary);
			clear_polygon();
		end
	endfunction

	function automatic void check_result(input ppbu_out_t got);
		ppbu_out_t want;
		beats_out++;
		if (polygon_results_q.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("result beat %0d arrived with no polygon closed: perim %0d",
					beats_out, got.perimeter);
		end else begin
			want = polygon_results_q.pop_front();
			if (got.perimeter !== want.perimeter ||
					got.perimeter_saturated !== want.perimeter_saturated ||
					got.box_x_min !== want.box_x_min || got.box_y_min !== want.box_y_min ||
					got.box_x_max !== want.box_x_max || got.box_y_max !== want.box_y_max) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("result beat %0d mismatch:", beats_out);
					$display("  exp perim %0d sat %b box (%0d,%0d)..(%0d,%0d)",
						want.perimeter, want.perimeter_saturated,
						want.box_x_min, want.box_y_min, want.box_x_max, want.box_y_max);
					$display("  got perim %0d sat %b box (%0d,%0d)..(%0d,%0d)",
						got.perimeter, got.perimeter_saturated,
						got.box_x_min, got.box_y_min, got.box_x_max, got.box_y_max);
				end
			end
		end
	endfunction

	// Track the channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_polygon();
			close_ring = 1'b1;
			polygon_results_q.delete();
			mismatches = 0;
			beats_out  = 0;
		end else begin
			if (cfg_we)
				close_ring = cfg_wdata;
			if (out_valid && out_ready)
				check_result(out_data);
			if (in_valid && in_ready)
				predict_vertex(in_data);
		end
		pending_results = polygon_results_q.size();
	end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the polygon perimeter and bounds unit.
// Directed polygons at the coordinate extremes and with both close_ring
// settings, a long receiver hold-off that backs the unit up, then random
// polygons with random idling on both sides. Checking lives in
// perimeter_bounds_checker.
// ----------------------------------------------------------------------------

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ppbu_pkg::*;

	localparam int RESET_CYCLES   = 8;
	localparam int SETTLE_CYCLES  = 64;     // longer than the worst-case vertex
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int HOLD_CYCLES    = 3000;
	localparam int RANDOM_ITEMS   = 1440;
	localparam int PHASE_ITEMS    = 260;
	localparam logic signed [COORD_BITS-1:0] C_MIN = 16'h8000;
	localparam logic signed [COORD_BITS-1:0] C_MAX = 16'h7fff;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	ppbu_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	ppbu_out_t out_data;
	logic      cfg_we;
	logic      cfg_wdata;

	int mismatches;
	int pending_results;
	int idle_cycles = 0;
	int items_sent  = 0;
	int rx_stall_pct = 0;
	bit tx_idle_on   = 1'b0;
	bit rx_hold_go   = 1'b0;

	always #5ns clk = ~clk;

	polygon_perimeter_and_bounds_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	perimeter_bounds_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.mismatches      (mismatches),
		.pending_results (pending_results)
	);

	// Watchdog: too long without any beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("** polygon_perimeter_and_bounds_unit: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic int polygon_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 1;
		if (r < 70) return $urandom_range(2, 6);
		if (r < 95) return $urandom_range(7, 16);
		return $urandom_range(17, 40);
	endfunction

	// Extremes, anywhere, or a cluster around the polygon's center
	function automatic logic signed [COORD_BITS-1:0] pick_coord(
		input logic signed [COORD_BITS-1:0] center);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return $urandom_range(0, 1) ? C_MAX : C_MIN;
		if (r < 4) return COORD_BITS'($urandom);
		return COORD_BITS'(center + ($urandom_range(0, 256) - 128));
	endfunction

	// Receiver: random stalls plus one long hold-off when asked
	initial begin
		int hold_left;
		int stall_left;
		bit hold_used;
		hold_left  = 0;
		stall_left = 0;
		hold_used  = 1'b0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_go && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
				out_ready  <= 1'b0;
				stall_left = gap_len();
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// One vertex beat; returns on the falling edge after acceptance
	task automatic push_vertex(input logic signed [COORD_BITS-1:0] x, y, input logic last);
		in_data  <= '{vertex_x: x, vertex_y: y, last_vertex: last};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic tx_pause();
		int n;
		if (tx_idle_on) begin
			n = gap_len();
			if (n > 0) begin
				in_valid <= 1'b0;
				repeat (n) @(negedge clk);
			end
		end
	endtask

	// Hold the sender until every polygon result is back and the unit is quiet
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_close_ring(input logic value);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_polygon(input int n);
		logic signed [COORD_BITS-1:0] cx, cy;
		int k;
		cx = COORD_BITS'($urandom);
		cy = COORD_BITS'($urandom);
		for (k = 0; k < n; k++) begin
			push_vertex(pick_coord(cx), pick_coord(cy), k == n - 1);
			tx_pause();
		end
	endtask

	initial begin
		int phase;
		int phase_start;
		int k;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed, ring closed (reset value): single vertices, extreme box,
		// a 3-by-4 rectangle with exact edges, two-vertex and zero-length polygons
		push_vertex(16'sd0, 16'sd0, 1'b1);
		push_vertex(C_MIN, C_MAX, 1'b1);
		push_vertex(C_MIN, C_MIN, 1'b0);
		push_vertex(C_MAX, C_MIN, 1'b0);
		push_vertex(C_MAX, C_MAX, 1'b1);
		push_vertex(16'sd0, 16'sd0, 1'b0);
		push_vertex(16'sd3, 16'sd0, 1'b0);
		push_vertex(16'sd3, 16'sd4, 1'b0);
		push_vertex(16'sd0, 16'sd4, 1'b1);
		push_vertex(16'sd1, 16'sd1, 1'b0);
		push_vertex(-16'sd1, -16'sd1, 1'b1);
		push_vertex(16'sd5, 16'sd5, 1'b0);
		push_vertex(16'sd5, 16'sd5, 1'b1);
		wait_drain();

		// Directed, ring open
		write_close_ring(1'b0);
		push_vertex(C_MAX, C_MIN, 1'b1);
		push_vertex(C_MAX, C_MAX, 1'b0);
		push_vertex(C_MIN, C_MIN, 1'b0);
		push_vertex(-16'sd7, 16'sd12, 1'b1);
		push_vertex(-16'sd3, -16'sd4, 1'b0);
		push_vertex(16'sd0, 16'sd0, 1'b1);
		wait_drain();

		// Receiver holds off while small polygons keep coming
		write_close_ring(1'b1);
		rx_hold_go <= 1'b1;
		for (k = 0; k < 30; k++)
			send_polygon(3);
		wait_drain();

		// Random phases, register and idling reshuffled between them
		items_sent = 0;
		phase      = 0;
		while (items_sent < RANDOM_ITEMS) begin
			case (phase % 4)
				0: write_close_ring(1'b1);
				1: write_close_ring(1'b0);
				default: write_close_ring(1'($urandom_range(0, 1)));
			endcase
			tx_idle_on   = (phase % 3 != 0);
			rx_stall_pct <= (phase % 3 == 0) ? 0 : $urandom_range(10, 60);
			phase_start  = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS && items_sent < RANDOM_ITEMS) begin
				send_polygon(polygon_size());
				if ($urandom_range(0, 99) < 4)
					wait_drain();
			end
			wait_drain();
			phase++;
		end

		if (mismatches == 0)
			$display("** polygon_perimeter_and_bounds_unit: PASSED **");
		else
			$display("** polygon_perimeter_and_bounds_unit: FAILED **");
		$finish;
	end

endmodule
